// File: src/svpwm_pkg.sv
`timescale 1ns / 1ps
package svpwm_pkg;

  localparam int unsigned CntW     = 16;
  localparam int unsigned DataW    = 16;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DegW     = 8;
  localparam int unsigned ProdW    = DegW + DataW;
  localparam int unsigned QuotInW  = ProdW - 2;
  localparam int unsigned RecipW   = 23;
  localparam int unsigned RecipSh  = 28;
  localparam int unsigned MulW     = QuotInW + RecipW;

  // floor(p / 180) = floor((p >> 2) * ceil(2^28 / 45) >> 28) for p below 2^24
  localparam logic [RecipW-1:0] Recip45 = 23'd5965233;

  localparam logic [DegW-1:0]  AngleMax     = 8'd180;
  localparam logic [DataW-1:0] PrescaleRst  = 16'd99;
  localparam logic [DataW-1:0] PeriodTopRst = 16'd19999;
  localparam logic [DataW-1:0] MinPulseRst  = 16'd1000;
  localparam logic [DataW-1:0] MaxPulseRst  = 16'd2000;
  localparam logic [DataW-1:0] CompareRst   = 16'd1500;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK  = 3'd0,
    CMD_PULSE = 3'd1,
    CMD_ANGLE = 3'd2,
    CMD_FORCE = 3'd3,
    CMD_START = 3'd4,
    CMD_STOP  = 3'd5
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRESCALE   = 3'd0,
    CFG_PERIOD_TOP = 3'd1,
    CFG_MIN_PULSE  = 3'd2,
    CFG_MAX_PULSE  = 3'd3,
    CFG_MODE_TWO   = 3'd4,
    CFG_PRELOAD_ON = 3'd5,
    CFG_OUT_EN     = 3'd6
  } cfg_idx_e;

endpackage

// File: src/svpwm_in_if.sv
`timescale 1ns / 1ps
interface svpwm_in_if
  import svpwm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [DataW-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// File: src/svpwm_out_if.sv
`timescale 1ns / 1ps
interface svpwm_out_if
  import svpwm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             pwm_pin;
  logic [CntW-1:0]  count_now;
  logic             update_event;
  logic [DataW-1:0] active_compare;

  modport source (output valid, output pwm_pin, output count_now, output update_event,
                  output active_compare, input ready);
  modport sink   (input valid, input pwm_pin, input count_now, input update_event,
                  input active_compare, output ready);
endinterface

// File: src/servo_pwm_timer_channel.sv
`timescale 1ns / 1ps
// channel  | direction | beat contents
// in_i     | sink      | cmd, value
// out_o    | source    | pwm_pin, count_now, update_event, active_compare
// cfg      | write     | cfg_we_i, cfg_index_i, cfg_wdata_i
//
// one beat accepted every cycle unless out_o stalls the pipe
// the two angle multiply stages lie ahead of the state update
// reset clears registers to defaults, counter stopped, compare 1500
// the whole pipe holds while a result waits and out_o is not ready
module servo_pwm_timer_channel
  import svpwm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_wdata_i,
  svpwm_in_if.sink           in_i,
  svpwm_out_if.source        out_o
);

  // configuration
  logic [DataW-1:0] prescale_q, period_top_q, min_pulse_q, max_pulse_q;
  logic             mode_two_q, preload_on_q, out_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q   <= PrescaleRst;
      period_top_q <= PeriodTopRst;
      min_pulse_q  <= MinPulseRst;
      max_pulse_q  <= MaxPulseRst;
      mode_two_q   <= 1'b0;
      preload_on_q <= 1'b1;
      out_en_q     <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PRESCALE:   prescale_q   <= cfg_wdata_i;
        CFG_PERIOD_TOP: period_top_q <= cfg_wdata_i;
        CFG_MIN_PULSE:  min_pulse_q  <= cfg_wdata_i;
        CFG_MAX_PULSE:  max_pulse_q  <= cfg_wdata_i;
        CFG_MODE_TWO:   mode_two_q   <= cfg_wdata_i[0];
        CFG_PRELOAD_ON: preload_on_q <= cfg_wdata_i[0];
        CFG_OUT_EN:     out_en_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // pipe advance
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // stage one: angle times span
  logic [DegW-1:0]  deg;
  logic [DataW-1:0] span;
  logic [ProdW-1:0] prod_d;
  logic             s1_valid_q;
  logic [CmdW-1:0]  s1_cmd_q;
  logic [DataW-1:0] s1_value_q;
  logic [ProdW-1:0] s1_prod_q;

  assign deg    = (in_i.value > DataW'(AngleMax)) ? AngleMax : in_i.value[DegW-1:0];
  assign span   = max_pulse_q - min_pulse_q;
  assign prod_d = ProdW'(deg) * ProdW'(span);

  // stage two: divide by 180 through the reciprocal
  logic [MulW-1:0]  mul_d;
  logic             s2_valid_q;
  logic [CmdW-1:0]  s2_cmd_q;
  logic [DataW-1:0] s2_value_q;
  logic [DataW-1:0] s2_quot_q;

  assign mul_d = MulW'(s1_prod_q[ProdW-1:2]) * MulW'(Recip45);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_i.valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_cmd_q   <= in_i.cmd;
      s1_value_q <= in_i.value;
      s1_prod_q  <= prod_d;
      s2_cmd_q   <= s1_cmd_q;
      s2_value_q <= s1_value_q;
      s2_quot_q  <= mul_d[RecipSh+DataW-1:RecipSh];
    end
  end

  // stage three: timer state
  logic [DataW-1:0] pre_cnt_q, pre_cnt_d;
  logic [CntW-1:0]  main_cnt_q, main_cnt_d;
  logic [DataW-1:0] pending_q, pending_d;
  logic [DataW-1:0] shadow_q, shadow_d;
  logic             running_q, running_d;
  logic             update_d;
  logic [DataW-1:0] pulse_raw, pulse_lo, pulse_clamp;
  logic             pin_d;
  logic             step;

  assign step        = en && s2_valid_q;
  assign pulse_raw   = (s2_cmd_q == CMD_ANGLE) ? (min_pulse_q + s2_quot_q) : s2_value_q;
  assign pulse_lo    = (pulse_raw < min_pulse_q) ? min_pulse_q : pulse_raw;
  assign pulse_clamp = (pulse_lo > max_pulse_q) ? max_pulse_q : pulse_lo;

  always_comb begin
    pre_cnt_d  = pre_cnt_q;
    main_cnt_d = main_cnt_q;
    pending_d  = pending_q;
    shadow_d   = shadow_q;
    running_d  = running_q;
    update_d   = 1'b0;
    case (s2_cmd_q)
      CMD_TICK: begin
        if (running_q) begin
          if (pre_cnt_q >= prescale_q) begin
            pre_cnt_d = '0;
            if (main_cnt_q >= CntW'(period_top_q)) begin
              main_cnt_d = '0;
              shadow_d   = pending_q;
              update_d   = 1'b1;
            end else begin
              main_cnt_d = main_cnt_q + 1'b1;
            end
          end else begin
            pre_cnt_d = pre_cnt_q + 1'b1;
          end
        end
      end
      CMD_PULSE, CMD_ANGLE: begin
        pending_d = pulse_clamp;
        if (!preload_on_q) begin
          shadow_d = pulse_clamp;
        end
      end
      CMD_FORCE: begin
        pre_cnt_d  = '0;
        main_cnt_d = '0;
        shadow_d   = pending_q;
        update_d   = 1'b1;
      end
      CMD_START: running_d = 1'b1;
      CMD_STOP:  running_d = 1'b0;
      default: ;
    endcase
  end

  assign pin_d = out_en_q & ((CntW'(shadow_d) > main_cnt_d) ^ mode_two_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_cnt_q  <= '0;
      main_cnt_q <= '0;
      pending_q  <= CompareRst;
      shadow_q   <= CompareRst;
      running_q  <= 1'b0;
    end else if (step) begin
      pre_cnt_q  <= pre_cnt_d;
      main_cnt_q <= main_cnt_d;
      pending_q  <= pending_d;
      shadow_q   <= shadow_d;
      running_q  <= running_d;
    end
  end

  // result register
  logic             out_pin_q;
  logic [CntW-1:0]  out_count_q;
  logic             out_update_q;
  logic [DataW-1:0] out_compare_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_pin_q     <= pin_d;
      out_count_q   <= main_cnt_d;
      out_update_q  <= update_d;
      out_compare_q <= shadow_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.pwm_pin        = out_pin_q;
  assign out_o.count_now      = out_count_q;
  assign out_o.update_event   = out_update_q;
  assign out_o.active_compare = out_compare_q;

  // checks
  a_update_clears_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_update_q |-> out_count_q == '0)
    else $error("update beat with non-zero count");

  a_shadow_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && preload_on_q && !update_d |=> shadow_q == $past(shadow_q))
    else $error("shadow compare changed without update");

  a_pending_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (s2_cmd_q == CMD_PULSE || s2_cmd_q == CMD_ANGLE) && min_pulse_q <= max_pulse_q
    |=> pending_q >= min_pulse_q && pending_q <= max_pulse_q)
    else $error("pending compare outside pulse limits");

  a_stopped_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && s2_cmd_q == CMD_TICK && !running_q
    |=> main_cnt_q == $past(main_cnt_q) && pre_cnt_q == $past(pre_cnt_q))
    else $error("counter moved while stopped");

endmodule
